FILE: hw/rtl/anc_pkg.sv
// Shared types, codes and lookup tables for the noise channel.
`timescale 1ns / 1ps

package anc_pkg;

	// Kinds of input word
	typedef enum logic [1:0] {
		REQ_WRITE    = 2'd0,
		REQ_TIMER    = 2'd1,
		REQ_ENVELOPE = 2'd2,
		REQ_LENGTH   = 2'd3
	} req_t;

	// Register offsets from the channel base
	localparam logic [1:0] REG_CTRL   = 2'd0;
	localparam logic [1:0] REG_SWEEP  = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;
	localparam logic [1:0] REG_LENGTH = 2'd3;

	localparam logic [14:0] LFSR_RESET = 15'h0001;
	localparam logic [3:0]  LEVEL_MAX  = 4'hF;

	// One input word as carried through the pipeline
	typedef struct packed {
		req_t       kind;
		logic [1:0] addr;
		logic [7:0] data;
	} item_t;

	// NTSC noise timer period lookup
	function automatic logic [11:0] noise_period(input logic [3:0] idx);
		logic [11:0] p;
		unique case (idx)
			4'd0:  p = 12'd4;
			4'd1:  p = 12'd8;
			4'd2:  p = 12'd16;
			4'd3:  p = 12'd32;
			4'd4:  p = 12'd64;
			4'd5:  p = 12'd96;
			4'd6:  p = 12'd128;
			4'd7:  p = 12'd160;
			4'd8:  p = 12'd202;
			4'd9:  p = 12'd254;
			4'd10: p = 12'd380;
			4'd11: p = 12'd508;
			4'd12: p = 12'd762;
			4'd13: p = 12'd1016;
			4'd14: p = 12'd2034;
			4'd15: p = 12'd4068;
		endcase
		return p;
	endfunction

	// Length counter load lookup
	function automatic logic [7:0] length_load(input logic [4:0] idx);
		logic [7:0] v;
		unique case (idx)
			5'd0:  v = 8'd10;
			5'd1:  v = 8'd254;
			5'd2:  v = 8'd20;
			5'd3:  v = 8'd2;
			5'd4:  v = 8'd40;
			5'd5:  v = 8'd4;
			5'd6:  v = 8'd80;
			5'd7:  v = 8'd6;
			5'd8:  v = 8'd160;
			5'd9:  v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd26;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			5'd31: v = 8'd30;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/anc_core.sv
// Channel state registers and the combinational update of one word.
`timescale 1ns / 1ps

module anc_core
	import anc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       fire,
	input  item_t      item,
	output logic [3:0] sample_nxt
);

	logic        enable_q;
	logic [14:0] lfsr_q, lfsr_d;
	logic        tap_mode_q, tap_mode_d;
	logic [11:0] period_q, period_d;
	logic [11:0] timer_q, timer_d;
	logic [7:0]  length_q, length_d;
	logic        halt_q, halt_d;
	logic        const_vol_q, const_vol_d;
	logic [3:0]  env_period_q, env_period_d;
	logic        env_restart_q, env_restart_d;
	logic [3:0]  env_level_q, env_level_d;
	logic [3:0]  env_div_q, env_div_d;
	logic        fb;

	// Next state for the word in hand
	always_comb begin
		lfsr_d        = lfsr_q;
		tap_mode_d    = tap_mode_q;
		period_d      = period_q;
		timer_d       = timer_q;
		length_d      = length_q;
		halt_d        = halt_q;
		const_vol_d   = const_vol_q;
		env_period_d  = env_period_q;
		env_restart_d = env_restart_q;
		env_level_d   = env_level_q;
		env_div_d     = env_div_q;
		fb = lfsr_q[0] ^ (tap_mode_q ? lfsr_q[6] : lfsr_q[1]);
		unique case (item.kind)
			REQ_WRITE: begin
				unique case (item.addr)
					REG_CTRL: begin
						halt_d       = item.data[5];
						const_vol_d  = item.data[4];
						env_period_d = item.data[3:0];
					end
					REG_SWEEP: begin
					end
					REG_PERIOD: begin
						tap_mode_d = item.data[7];
						period_d   = noise_period(item.data[3:0]);
					end
					REG_LENGTH: begin
						if (enable_q) length_d = length_load(item.data[7:3]);
						env_restart_d = 1'b1;
					end
				endcase
			end
			REQ_TIMER: begin
				// reload and shift on terminal count
				if (timer_q == 12'd0) begin
					timer_d = period_q;
					lfsr_d  = {fb, lfsr_q[14:1]};
				end else begin
					timer_d = timer_q - 12'd1;
				end
			end
			REQ_ENVELOPE: begin
				priority if (env_restart_q) begin
					env_restart_d = 1'b0;
					env_level_d   = LEVEL_MAX;
					env_div_d     = env_period_q;
				end else if (env_div_q == 4'd0) begin
					env_div_d = env_period_q;
					if (env_level_q != 4'd0) env_level_d = env_level_q - 4'd1;
					else if (halt_q) env_level_d = LEVEL_MAX;
				end else begin
					env_div_d = env_div_q - 4'd1;
				end
			end
			REQ_LENGTH: begin
				if (!halt_q && length_q != 8'd0) length_d = length_q - 8'd1;
			end
		endcase
		// output level after this word
		if (length_d == 8'd0 || lfsr_d[0]) sample_nxt = 4'd0;
		else sample_nxt = const_vol_d ? env_period_d : env_level_d;
	end

	// Hold state; advance on an accepted word, apply enable writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			lfsr_q        <= LFSR_RESET;
			tap_mode_q    <= 1'b0;
			period_q      <= '0;
			timer_q       <= '0;
			length_q      <= '0;
			halt_q        <= 1'b0;
			const_vol_q   <= 1'b0;
			env_period_q  <= '0;
			env_restart_q <= 1'b0;
			env_level_q   <= '0;
			env_div_q     <= '0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
			if (!cfg_wdata) length_q <= '0;
		end else if (fire) begin
			lfsr_q        <= lfsr_d;
			tap_mode_q    <= tap_mode_d;
			period_q      <= period_d;
			timer_q       <= timer_d;
			length_q      <= length_d;
			halt_q        <= halt_d;
			const_vol_q   <= const_vol_d;
			env_period_q  <= env_period_d;
			env_restart_q <= env_restart_d;
			env_level_q   <= env_level_d;
			env_div_q     <= env_div_d;
		end
	end

endmodule

FILE: hw/rtl/apu_noise_channel.sv
// Top level of the noise channel: input register, update core, result register.
`timescale 1ns / 1ps
//
// Noise voice of a sound chip. Each input word is a register write, a timer
// tick, an envelope clock or a length clock, chosen by req_type. Every word
// yields exactly one result word carrying the 4-bit sample after that word.
//
// Channels: in_valid/in_stall carry req_type, reg_addr, write_data; a word is
// taken on a rising edge with in_valid high and in_stall low. out_valid/
// out_stall carry sample the same way. cfg_we/cfg_wdata write channel_enable;
// clearing it zeroes the length counter. Write it only while idle.
//
// An accepted word is held in the input register, then its result in the result
// register, where out_valid rises. Throughput: one word per cycle while the
// receiver does not stall; the state update is one pass through the core between the
// input register and the result register.
// Reset (arst_n low) empties both registers and returns the channel to its
// power-up state: LFSR at one, counters and envelope at zero, disabled.
// When the receiver stalls, the result holds; one more word may enter the
// input register, after which in_stall rises until the result is taken.

module apu_noise_channel
	import anc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [1:0] reg_addr,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] sample
);

	item_t      item_s1;
	logic       valid_s1;
	logic       fire;
	logic [3:0] sample_nxt;
	logic [3:0] sample_s2;
	logic       valid_s2;

	// Process the held word when the result slot is free or draining
	assign fire     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.kind <= req_t'(req_type);
			item_s1.addr <= reg_addr;
			item_s1.data <= write_data;
		end
	end

	anc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fire       (fire),
		.item       (item_s1),
		.sample_nxt (sample_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) sample_s2 <= sample_nxt;
	end

	assign out_valid = valid_s2;
	assign sample    = sample_s2;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the noise channel: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module testbench;
	import anc_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] req_type = REQ_WRITE;
	logic [1:0] reg_addr = REG_CTRL;
	logic [7:0] write_data = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [3:0] sample;

	// Idle percentages for the sending and receiving sides, set per phase
	int send_gap_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;

	apu_noise_channel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.reg_addr  (reg_addr),
		.write_data(write_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

	// Noise voice predictor plus the queue of samples still owed by the block
	class noise_scoreboard;
		bit          enable;
		logic [14:0] lfsr;
		bit          tap_mode;
		logic [11:0] timer_period;
		logic [11:0] timer_count;
		logic [7:0]  length_count;
		bit          length_halt;
		bit          constant_volume;
		logic [3:0]  envelope_period;
		bit          envelope_restart;
		logic [3:0]  envelope_level;
		logic [3:0]  envelope_divider;
		logic [11:0] period_lut[16];
		logic [7:0]  length_lut[32];
		logic [3:0]  owed_samples[$];
		int          mismatches;
		int          checked;
		int          nonzero;

		function new();
			period_lut = '{12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
				12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068};
			length_lut = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
				8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
				8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
				8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
			enable = 1'b0;
			lfsr = LFSR_RESET;
			tap_mode = 1'b0;
			timer_period = '0;
			timer_count = '0;
			length_count = '0;
			length_halt = 1'b0;
			constant_volume = 1'b0;
			envelope_period = '0;
			envelope_restart = 1'b0;
			envelope_level = '0;
			envelope_divider = '0;
			mismatches = 0;
			checked = 0;
			nonzero = 0;
		endfunction

		// Disabling the channel drops the length counter to zero
		function void set_enable(bit v);
			enable = v;
			if (!v)
				length_count = '0;
		endfunction

		// Advance the predicted state by one accepted word and queue its sample
		function void note_word(req_t kind, logic [1:0] addr, logic [7:0] data);
			logic [3:0] level;
			case (kind)
				REQ_WRITE: begin
					case (addr)
						REG_CTRL: begin
							length_halt = data[5];
							constant_volume = data[4];
							envelope_period = data[3:0];
						end
						REG_PERIOD: begin
							tap_mode = data[7];
							timer_period = period_lut[data[3:0]];
						end
						REG_LENGTH: begin
							if (enable)
								length_count = length_lut[data[7:3]];
							envelope_restart = 1'b1;
						end
						default: ;
					endcase
				end
				REQ_TIMER: begin
					if (timer_count == '0) begin
						timer_count = timer_period;
						lfsr = {lfsr[0] ^ (tap_mode ? lfsr[6] : lfsr[1]), lfsr[14:1]};
					end else begin
						timer_count = timer_count - 12'd1;
					end
				end
				REQ_ENVELOPE: begin
					if (envelope_restart) begin
						envelope_restart = 1'b0;
						envelope_level = LEVEL_MAX;
						envelope_divider = envelope_period;
					end else if (envelope_divider == '0) begin
						envelope_divider = envelope_period;
						if (envelope_level != '0)
							envelope_level = envelope_level - 4'd1;
						else if (length_halt)
							envelope_level = LEVEL_MAX;
					end else begin
						envelope_divider = envelope_divider - 4'd1;
					end
				end
				default: begin
					if (!length_halt && length_count != '0)
						length_count = length_count - 8'd1;
				end
			endcase
			if (length_count == '0 || lfsr[0])
				level = 4'd0;
			else
				level = constant_volume ? envelope_period : envelope_level;
			owed_samples.push_back(level);
		endfunction

		// Compare one taken sample with the oldest one owed
		function void check_sample(logic [3:0] got);
			logic [3:0] want;
			if (owed_samples.size() == 0) begin
				$display("%0t: sample %0d arrived with nothing expected", $realtime, got);
				mismatches++;
			end else begin
				want = owed_samples.pop_front();
				checked++;
				if (got !== want) begin
					$display("%0t: sample mismatch, expected %0d, actual %0d",
						$realtime, want, got);
					mismatches++;
				end else if (got != '0) begin
					nonzero++;
				end
			end
		endfunction

		function int pending();
			return owed_samples.size();
		endfunction
	endclass

	noise_scoreboard board;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// Limit on the whole run
	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Take result words, stalling at random
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_sample(sample);
			if (hold == 0)
				hold = pick_gap(stall_pct);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Present one word, hold it until taken, then note it
	task automatic send_word(req_t kind, logic [1:0] addr, logic [7:0] data);
		int gap;
		gap = pick_gap(send_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		reg_addr <= addr;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		board.note_word(kind, addr, data);
		words_sent++;
	endtask

	// Drop valid after the last word of a stretch
	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain the block, let it settle, then write the enable register
	task automatic write_enable(bit v);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_enable(v);
	endtask

	// Random word: mostly timer ticks and clocks, short periods so the LFSR keeps moving
	task automatic send_random_word();
		int r;
		logic [1:0] a;
		logic [7:0] d;
		r = $urandom_range(0, 99);
		a = 2'($urandom_range(0, 3));
		d = 8'($urandom_range(0, 255));
		if (r < 50) begin
			send_word(REQ_TIMER, a, d);
		end else if (r < 68) begin
			send_word(REQ_ENVELOPE, a, d);
		end else if (r < 80) begin
			send_word(REQ_LENGTH, a, d);
		end else begin
			if (a == REG_PERIOD) begin
				r = $urandom_range(0, 99);
				if (r < 85) begin
					d[3:0] = 4'($urandom_range(0, 3));
				end else if (r < 92) begin
					d[3:0] = 4'($urandom_range(4, 6));
				end else begin
					// long period, replaced before the timer can reload from it
					d[3:0] = 4'($urandom_range(7, 15));
					send_word(REQ_WRITE, a, d);
					d = 8'($urandom_range(0, 255));
					d[3:0] = 4'($urandom_range(0, 3));
				end
			end
			send_word(REQ_WRITE, a, d);
		end
	endtask

	initial begin
		int phase;
		int n;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words
		send_gap_pct = 20;
		stall_pct = 20;
		write_enable(1'b1);
		send_word(REQ_WRITE, REG_CTRL, 8'h00);
		send_word(REQ_WRITE, REG_PERIOD, 8'h00);
		send_word(REQ_WRITE, REG_LENGTH, 8'hFF);
		send_word(REQ_ENVELOPE, 2'd0, 8'h00);
		send_word(REQ_TIMER, 2'd3, 8'hFF);
		send_word(REQ_TIMER, 2'd0, 8'h00);
		send_word(REQ_ENVELOPE, 2'd0, 8'h00);
		send_word(REQ_LENGTH, 2'd0, 8'h00);
		send_word(REQ_WRITE, REG_SWEEP, 8'hFF);
		send_word(REQ_WRITE, REG_CTRL, 8'h3F);
		send_word(REQ_LENGTH, 2'd0, 8'h00);
		send_word(REQ_WRITE, REG_PERIOD, 8'h8F);
		send_word(REQ_TIMER, 2'd0, 8'h00);
		send_word(REQ_WRITE, REG_PERIOD, 8'h80);
		repeat (4) send_word(REQ_TIMER, 2'd0, 8'h00);
		send_word(REQ_WRITE, REG_CTRL, 8'h20);
		send_word(REQ_ENVELOPE, 2'd0, 8'h00);
		send_word(REQ_WRITE, REG_LENGTH, 8'h00);
		send_word(REQ_ENVELOPE, 2'd0, 8'h00);
		stop_sending();
		// disabled channel: counter cleared, length write does not load
		write_enable(1'b0);
		send_word(REQ_WRITE, REG_LENGTH, 8'hF8);
		send_word(REQ_LENGTH, 2'd0, 8'h00);
		send_word(REQ_TIMER, 2'd0, 8'h00);
		stop_sending();

		// Random phases with different idling on each side
		for (phase = 0; phase < 5; phase++) begin
			write_enable(phase == 2 ? 1'b0 : 1'b1);
			case (phase)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 30; stall_pct = 30; end
				2: begin send_gap_pct = 50; stall_pct = 10; end
				3: begin send_gap_pct = 10; stall_pct = 60; end
				default: begin send_gap_pct = 40; stall_pct = 40; end
			endcase
			for (n = 0; n < 110; n++)
				send_random_word();
			stop_sending();
		end

		// Drain and settle
		stall_pct = 0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("testbench: %0d words sent, %0d samples checked, %0d of them nonzero",
			words_sent, board.checked, board.nonzero);
		$display("testbench: all word kinds, channel on and off, idling on both sides");
		if (board.mismatches == 0 && board.pending() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
